FILE: rtl/fccw_pkg.sv
// Shared constants, widths and codes of the FAT cluster chain walker.
package fccw_pkg;

    localparam int TABLE_DEPTH = 8192;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    localparam int KIND_W   = 2;
    localparam int IDX_W    = 13;
    localparam int RAW_W    = 32;
    localparam int CLU_W    = 28;
    localparam int SEC_W    = 49;
    localparam int CNT_W    = 20;
    localparam int DSS_W    = 48;
    localparam int SPC_W    = 8;
    localparam int BPS_W    = 13;
    localparam int TEV_W    = 14;
    localparam int PROD_W   = CLU_W + SPC_W;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = DSS_W;

    localparam logic [CLU_W-1:0] END_MARK_LOW      = 28'hFFFFFF8;
    localparam logic [RAW_W-1:0] ENTRY_MASK        = 32'h0FFFFFFF;
    localparam logic [CNT_W-1:0] MAX_CLUSTER_BYTES = 20'd524288;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_START = 2'd1,
        KIND_STEP  = 2'd2
    } t_kind;

    typedef enum logic [CFG_AW-1:0] {
        CFG_DATA_START = 2'd0,
        CFG_SPC        = 2'd1,
        CFG_BPS        = 2'd2,
        CFG_TEV        = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } t_state;

    function automatic logic usable_cluster(input logic [RAW_W-1:0] c);
        return (c >= RAW_W'(2)) && (c < RAW_W'(END_MARK_LOW));
    endfunction

endpackage

FILE: rtl/fccw_word_if.sv
// Input channel: table writes, walk starts and walk steps.
interface fccw_word_if import fccw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  entry_index;
    logic [RAW_W-1:0]  entry_value;
    logic [RAW_W-1:0]  head_cluster;
    logic [RAW_W-1:0]  file_bytes;
    logic [RAW_W-1:0]  buffer_bytes;

    modport source (
        output valid, kind, entry_index, entry_value, head_cluster, file_bytes,
               buffer_bytes,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, entry_value, head_cluster, file_bytes,
               buffer_bytes,
        output ready
    );
endinterface

FILE: rtl/fccw_desc_if.sv
// Output channel: read descriptors.
interface fccw_desc_if import fccw_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CLU_W-1:0] cluster_number;
    logic [SEC_W-1:0] start_sector;
    logic [CNT_W-1:0] byte_count;
    logic             last;

    modport source (
        output valid, cluster_number, start_sector, byte_count, last,
        input  ready
    );
    modport sink (
        input  valid, cluster_number, start_sector, byte_count, last,
        output ready
    );
endinterface

FILE: rtl/fat_cluster_chain_walker.sv
// Top level of the FAT cluster chain walker.
//
//   channel   dir  handshake         word
//   i_word    in   valid/ready       kind, entry_index, entry_value, head_cluster, ...
//   o_desc    out  valid/ready       cluster_number, start_sector, byte_count, last
//   i_cfg_*   in   i_cfg_we only     register index, 48-bit data
//
// Write and start words are taken in ST_IDLE; a step word reads the chain
// table when it is accepted and moves to ST_STEP, which loads the descriptor
// and next cluster from the registered RAM output. The single read port of the
// chain table paces the walk. A step holds in ST_STEP while the output
// register is still full. Reset clears the walk state, the output valid and
// the configuration registers; table contents stay undefined until written.
module fat_cluster_chain_walker import fccw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    fccw_word_if.sink         i_word,
    fccw_desc_if.source       o_desc
);
    t_state             r_state, n_state;
    logic               r_active, n_active;
    logic [CLU_W-1:0]   r_cur, n_cur;
    logic [RAW_W-1:0]   r_bytes, n_bytes;
    logic [RAW_W-1:0]   r_space, n_space;
    logic [PROD_W-1:0]  r_prod;
    logic [CNT_W-1:0]   r_clu_bytes;

    logic [DSS_W-1:0]   r_dss;
    logic [SPC_W-1:0]   r_spc;
    logic [BPS_W-1:0]   r_bps;
    logic [TEV_W-1:0]   r_tev;

    logic               r_out_valid, n_out_valid;
    logic [CLU_W-1:0]   r_o_cluster;
    logic [SEC_W-1:0]   r_o_sector;
    logic [CNT_W-1:0]   r_o_count;
    logic               r_o_last;

    logic               w_acc, w_step_go, w_slot_free, w_load;
    logic [RAW_W-1:0]   w_idx32;
    logic               w_ram_we, w_ram_re;
    logic [CLU_W-1:0]   w_next;
    logic [CLU_W-1:0]   w_rdata;
    logic [RAW_W-1:0]   w_cnt_a, w_cnt;
    logic [RAW_W-1:0]   w_bytes_left, w_space_left;
    logic               w_in_range, w_ends;
    logic [PROD_W-1:0]  w_prod;
    logic [20:0]        w_clu_raw;
    logic [CNT_W-1:0]   w_clu_sat;

    assign w_acc       = i_word.valid && i_word.ready;
    assign w_slot_free = !r_out_valid || o_desc.ready;
    assign w_idx32     = RAW_W'(i_word.entry_index);

    assign w_ram_we  = w_acc && (i_word.kind == KIND_WRITE) && (w_idx32 < RAW_W'(TABLE_DEPTH));
    assign w_step_go = w_acc && (i_word.kind == KIND_STEP) && r_active;
    assign w_ram_re  = w_step_go;

    fccw_ram #(
        .WIDTH (CLU_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_idx32[TBL_AW-1:0]),
        .i_wdata (CLU_W'(i_word.entry_value & ENTRY_MASK)),
        .i_re    (w_ram_re),
        .i_raddr (RAW_W'(r_cur) < RAW_W'(TABLE_DEPTH) ? r_cur[TBL_AW-1:0] : '0),
        .o_rdata (w_rdata)
    );

    // step-accept arithmetic: sector offset and saturated cluster size
    assign w_prod    = PROD_W'(r_cur - CLU_W'(2)) * PROD_W'(r_spc);
    assign w_clu_raw = 21'(r_spc) * 21'(r_bps);
    assign w_clu_sat = (w_clu_raw > 21'(MAX_CLUSTER_BYTES)) ? MAX_CLUSTER_BYTES
                                                              : w_clu_raw[CNT_W-1:0];

    // ST_STEP: byte count, remaining, chain follow
    assign w_cnt_a      = (RAW_W'(r_clu_bytes) > r_bytes) ? r_bytes : RAW_W'(r_clu_bytes);
    assign w_cnt        = (w_cnt_a > r_space) ? r_space : w_cnt_a;
    assign w_bytes_left = r_bytes - w_cnt;
    assign w_space_left = r_space - w_cnt;
    assign w_in_range   = (RAW_W'(r_cur) < RAW_W'(r_tev))
                       && (RAW_W'(r_cur) < RAW_W'(TABLE_DEPTH));
    assign w_next       = w_rdata;
    assign w_ends       = (w_bytes_left == '0) || (w_space_left == '0) || !w_in_range
                       || !usable_cluster(RAW_W'(w_next));
    assign w_load       = (r_state == ST_STEP) && w_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_cur       <= '0;
            r_bytes     <= '0;
            r_space     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_cur       <= n_cur;
            r_bytes     <= n_bytes;
            r_space     <= n_space;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dss <= '0;
            r_spc <= SPC_W'(1);
            r_bps <= BPS_W'(512);
            r_tev <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DATA_START: r_dss <= i_cfg_data[DSS_W-1:0];
                CFG_SPC:        r_spc <= i_cfg_data[SPC_W-1:0];
                CFG_BPS:        r_bps <= i_cfg_data[BPS_W-1:0];
                CFG_TEV:        r_tev <= i_cfg_data[TEV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step_go) begin
            r_prod      <= w_prod;
            r_clu_bytes <= w_clu_sat;
        end
        if (w_load) begin
            r_o_cluster <= r_cur;
            r_o_sector  <= SEC_W'(r_dss) + SEC_W'(r_prod);
            r_o_count   <= w_cnt[CNT_W-1:0];
            r_o_last    <= w_ends;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_cur       = r_cur;
        n_bytes     = r_bytes;
        n_space     = r_space;
        n_out_valid = r_out_valid && !o_desc.ready;
        i_word.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_word.ready = 1'b1;
                if (w_acc && i_word.kind == KIND_START) begin
                    n_cur    = CLU_W'(i_word.head_cluster & ENTRY_MASK);
                    n_bytes  = i_word.file_bytes;
                    n_space  = i_word.buffer_bytes;
                    n_active = usable_cluster(i_word.head_cluster)
                            && (i_word.file_bytes != '0) && (i_word.buffer_bytes != '0);
                end
                if (w_step_go) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_bytes     = w_bytes_left;
                    n_space     = w_space_left;
                    n_active    = !w_ends;
                    if (!w_ends) begin
                        n_cur = w_next;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_desc.valid          = r_out_valid;
    assign o_desc.cluster_number = r_o_cluster;
    assign o_desc.start_sector   = r_o_sector;
    assign o_desc.byte_count     = r_o_count;
    assign o_desc.last           = r_o_last;
endmodule

FILE: rtl/fccw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/fccw_checker.sv
// Port-level checks for the FAT cluster chain walker, bound to the top level.
module fccw_checker import fccw_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [KIND_W-1:0] i_in_kind,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CNT_W-1:0]  i_out_count,
    input logic [CLU_W-1:0]  i_out_cluster
);
    logic w_step_acc;
    assign w_step_acc = i_in_valid && i_in_ready && (i_in_kind == KIND_STEP);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_cluster))
        else $error("descriptor dropped or changed while stalled");

    a_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_step_acc, 2))
        else $error("descriptor without a step word");

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_acc |=> !i_in_ready || !i_out_valid || $past(i_out_valid))
        else $error("input taken during step cycle");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_count <= MAX_CLUSTER_BYTES)
        else $error("byte count above cluster limit");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("descriptor valid after reset");
endmodule

bind fat_cluster_chain_walker fccw_checker u_fccw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_word.valid),
    .i_in_ready    (i_word.ready),
    .i_in_kind     (i_word.kind),
    .i_out_valid   (o_desc.valid),
    .i_out_ready   (o_desc.ready),
    .i_out_count   (o_desc.byte_count),
    .i_out_cluster (o_desc.cluster_number)
);

FILE: test/fat_cluster_chain_walker_test.sv
// Testbench for the cluster chain walker: directed and random table loads and walks checked against a predictor.
module fat_cluster_chain_walker_test;
    import fccw_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned REGION_TOP  = 49;    // most chains live in clusters 2..49
    localparam int unsigned PHASE_WORDS = 65;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned MAX_SHOWN   = 40;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  entry_index;
        logic [RAW_W-1:0]  entry_value;
        logic [RAW_W-1:0]  head_cluster;
        logic [RAW_W-1:0]  file_bytes;
        logic [RAW_W-1:0]  buffer_bytes;
    } word_t;

    typedef struct packed {
        logic [CLU_W-1:0] cluster;
        logic [SEC_W-1:0] sector;
        logic [CNT_W-1:0] count;
        logic             last;
    } desc_t;

    class walk_scoreboard;
        logic [CLU_W-1:0] links [TABLE_DEPTH];
        bit               loaded [TABLE_DEPTH];
        logic [CLU_W-1:0] cur_cluster;
        logic [RAW_W-1:0] bytes_left;
        logic [RAW_W-1:0] space_left;
        bit               walking;
        logic [DSS_W-1:0] data_start;
        logic [SPC_W-1:0] spc;
        logic [BPS_W-1:0] bps;
        logic [TEV_W-1:0] entries_valid;
        desc_t            due_q[$];
        int unsigned      errors;

        function new();
            cur_cluster   = '0;
            bytes_left    = '0;
            space_left    = '0;
            walking       = 0;
            data_start    = '0;
            spc           = 1;
            bps           = 512;
            entries_valid = '0;
            errors        = 0;
        endfunction

        static function bit good_link(logic [RAW_W-1:0] c);
            return (c >= 32'd2) && (c < {4'h0, END_MARK_LOW});
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_DATA_START: data_start    = data[DSS_W-1:0];
                CFG_SPC:        spc           = data[SPC_W-1:0];
                CFG_BPS:        bps           = data[BPS_W-1:0];
                CFG_TEV:        entries_valid = data[TEV_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [RAW_W-1:0] clu_size();
            logic [RAW_W-1:0] b;
            b = RAW_W'(spc) * RAW_W'(bps);
            if (b > RAW_W'(MAX_CLUSTER_BYTES)) b = RAW_W'(MAX_CLUSTER_BYTES);
            return b;
        endfunction

        function logic [RAW_W-1:0] take_bytes();
            logic [RAW_W-1:0] b;
            b = clu_size();
            if (b > bytes_left) b = bytes_left;
            if (b > space_left) b = space_left;
            return b;
        endfunction

        // True when the next step would look up a table entry never loaded.
        function bit lookup_pending(output int unsigned idx);
            logic [RAW_W-1:0] take;
            take = take_bytes();
            idx  = 32'(cur_cluster);
            return walking && bytes_left != take && space_left != take
                && cur_cluster < entries_valid && cur_cluster < TABLE_DEPTH
                && !loaded[cur_cluster];
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        function void note_word(word_t w);
            desc_t            d;
            logic [RAW_W-1:0] take;
            logic [CLU_W-1:0] nxt;
            bit               stop;
            case (w.kind)
                KIND_WRITE: begin
                    links[w.entry_index]  = w.entry_value[CLU_W-1:0];
                    loaded[w.entry_index] = 1;
                end
                KIND_START: begin
                    cur_cluster = w.head_cluster[CLU_W-1:0];
                    bytes_left  = w.file_bytes;
                    space_left  = w.buffer_bytes;
                    walking     = good_link(w.head_cluster) && w.file_bytes != 0
                                  && w.buffer_bytes != 0;
                end
                KIND_STEP: begin
                    if (walking) begin
                        take = take_bytes();
                        bytes_left -= take;
                        space_left -= take;
                        d.cluster = cur_cluster;
                        d.sector  = SEC_W'(data_start)
                                    + SEC_W'(cur_cluster - CLU_W'(2)) * SEC_W'(spc);
                        d.count   = CNT_W'(take);
                        stop = 0;
                        if (bytes_left == 0 || space_left == 0) begin
                            stop = 1;
                        end else if (cur_cluster >= entries_valid
                                     || cur_cluster >= TABLE_DEPTH) begin
                            stop = 1;
                        end else begin
                            nxt = links[cur_cluster];
                            if (good_link({4'h0, nxt})) cur_cluster = nxt;
                            else stop = 1;
                        end
                        d.last = stop;
                        if (stop) walking = 0;
                        due_q.push_back(d);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            if (errors < MAX_SHOWN) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(desc_t got);
            desc_t want;
            if (due_q.size() == 0) begin
                report($sformatf("descriptor for cluster %0h with none due", got.cluster));
                return;
            end
            want = due_q.pop_front();
            if (got.cluster !== want.cluster)
                report($sformatf("cluster %0h, want %0h", got.cluster, want.cluster));
            if (got.sector !== want.sector)
                report($sformatf("cluster %0h sector %0h, want %0h",
                                 want.cluster, got.sector, want.sector));
            if (got.count !== want.count)
                report($sformatf("cluster %0h byte count %0d, want %0d",
                                 want.cluster, got.count, want.count));
            if (got.last !== want.last)
                report($sformatf("cluster %0h last %b, want %b",
                                 want.cluster, got.last, want.last));
        endtask

        task finish();
            while (due_q.size() != 0) begin
                report($sformatf("descriptor for cluster %0h never came",
                                 due_q[0].cluster));
                void'(due_q.pop_front());
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    fccw_word_if word_ch ();
    fccw_desc_if desc_ch ();

    walk_scoreboard sb;
    bit             tx_idle;
    bit             rx_idle;
    bit             hold_done;
    int unsigned    n_descs;

    fat_cluster_chain_walker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_word     (word_ch),
        .o_desc     (desc_ch)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic word_t noise_word();
        word_t w;
        w.kind          = KIND_W'($urandom_range(0, 3));
        w.entry_index   = IDX_W'($urandom);
        w.entry_value   = $urandom;
        w.head_cluster  = $urandom;
        w.file_bytes    = $urandom;
        w.buffer_bytes  = $urandom;
        return w;
    endfunction

    function automatic word_t mk_word(logic [KIND_W-1:0] kind);
        word_t w;
        w      = noise_word();
        w.kind = kind;
        return w;
    endfunction

    function automatic word_t mk_write(logic [IDX_W-1:0] idx, logic [RAW_W-1:0] val);
        word_t w;
        w             = mk_word(KIND_WRITE);
        w.entry_index = idx;
        w.entry_value = val;
        return w;
    endfunction

    function automatic word_t mk_start(logic [RAW_W-1:0] first, logic [RAW_W-1:0] fbytes,
                                       logic [RAW_W-1:0] bbytes);
        word_t w;
        w               = mk_word(KIND_START);
        w.head_cluster  = first;
        w.file_bytes    = fbytes;
        w.buffer_bytes  = bbytes;
        return w;
    endfunction

    // Mostly links inside the working region; the rest end marks, free/reserved
    // values, clusters around the end of the table and random values. Upper nibble is noise.
    function automatic logic [RAW_W-1:0] link_value();
        logic [CLU_W-1:0] nxt;
        case ($urandom_range(0, 9))
            0: nxt = CLU_W'($urandom_range(0, 1));
            1: nxt = END_MARK_LOW + CLU_W'($urandom_range(0, 7));
            2: nxt = CLU_W'($urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 64));
            3: nxt = CLU_W'($urandom);
            default: nxt = CLU_W'($urandom_range(2, REGION_TOP));
        endcase
        return {4'($urandom), nxt};
    endfunction

    function automatic word_t good_start();
        word_t            w;
        logic [RAW_W-1:0] csz;
        logic [RAW_W-1:0] span;
        w      = mk_word(KIND_START);
        csz    = sb.clu_size();
        span   = (csz == 0) ? 32'd65536 : csz * 6;
        case ($urandom_range(0, 9))
            0: w.head_cluster = $urandom_range(TABLE_DEPTH - 12, TABLE_DEPTH - 1);
            1: w.head_cluster = $urandom_range(2, 32'h0FFF_FFF7);
            default: w.head_cluster = $urandom_range(2, REGION_TOP);
        endcase
        if ($urandom_range(0, 3) != 0) w.file_bytes = $urandom_range(1, span);
        if ($urandom_range(0, 3) != 0) w.buffer_bytes = $urandom_range(1, span);
        return w;
    endfunction

    function automatic word_t pick_word();
        word_t       w;
        int unsigned idx;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (sb.lookup_pending(idx)) begin
            w = mk_write(IDX_W'(idx), link_value());
        end else if (r < 10) begin
            w = mk_write(($urandom_range(0, 3) == 0) ? IDX_W'($urandom)
                         : IDX_W'($urandom_range(0, REGION_TOP + 2)), link_value());
        end else if (r < 16) begin
            w = good_start();
            case ($urandom_range(0, 4))
                0: w.head_cluster = $urandom_range(0, 1);
                1: w.head_cluster = $urandom_range(32'h0FFF_FFF8, 32'hFFFF_FFFF);
                2: w.file_bytes = '0;
                3: w.buffer_bytes = '0;
                default: ;
            endcase
        end else if (r < 19) begin
            w = mk_word(($urandom_range(0, 1) == 0) ? KIND_UNUSED : KIND_STEP);
        end else if (sb.walking) begin
            w = mk_word(KIND_STEP);
        end else begin
            w = good_start();
        end
        return w;
    endfunction

    task automatic send(word_t w);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            word_ch.valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        word_ch.valid         <= 1;
        word_ch.kind          <= w.kind;
        word_ch.entry_index   <= w.entry_index;
        word_ch.entry_value   <= w.entry_value;
        word_ch.head_cluster  <= w.head_cluster;
        word_ch.file_bytes    <= w.file_bytes;
        word_ch.buffer_bytes  <= w.buffer_bytes;
        do @(posedge i_clk); while (!word_ch.ready);
        sb.note_word(w);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 0;
        sb.set_reg(idx, data);
    endtask

    task automatic load_regs(logic [DSS_W-1:0] dss, logic [SPC_W-1:0] spc,
                             logic [BPS_W-1:0] bps, logic [TEV_W-1:0] tev);
        write_reg(CFG_DATA_START, CFG_DW'(dss));
        write_reg(CFG_SPC, CFG_DW'(spc));
        write_reg(CFG_BPS, CFG_DW'(bps));
        write_reg(CFG_TEV, CFG_DW'(tev));
    endtask

    // Drop valid, let every due descriptor drain, then let the pipe settle.
    task automatic quiesce();
        @(negedge i_clk);
        word_ch.valid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        word_t       w;
        int unsigned counted;
        sb                    = new();
        tx_idle               = 1;
        rx_idle               = 1;
        i_rst_n               = 0;
        i_cfg_we              = 0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        word_ch.valid         = 0;
        word_ch.kind          = '0;
        word_ch.entry_index   = '0;
        word_ch.entry_value   = '0;
        word_ch.head_cluster  = '0;
        word_ch.file_bytes    = '0;
        word_ch.buffer_bytes  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: saturated cluster size, top of the sector range
        load_regs(48'hFFFF_FFFF_FFFF, 8'd255, 13'd8191, 14'd8192);
        send(mk_word(KIND_STEP));                       // step with no walk armed
        send(mk_word(KIND_UNUSED));
        send(mk_write(13'd8191, 32'hFFFF_FFFF));
        send(mk_write(13'd2, 32'h0000_0003));
        send(mk_write(13'd3, 32'h1000_0005));          // upper nibble dropped
        send(mk_write(13'd5, 32'hFFFF_FFF7));          // highest usable cluster
        send(mk_start(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        repeat (4) send(mk_word(KIND_STEP));           // 2, 3, 5, then out of range
        send(mk_start(32'd1, 32'd4096, 32'd4096));
        send(mk_word(KIND_STEP));
        send(mk_start(32'h0FFF_FFF8, 32'd4096, 32'd4096));
        send(mk_word(KIND_STEP));
        send(mk_start(32'd2, 32'd0, 32'd100));
        send(mk_start(32'd2, 32'd100, 32'd0));
        send(mk_start(32'd8191, 32'd1000, 32'd600));   // buffer runs out first
        send(mk_word(KIND_STEP));
        send(mk_write(13'd6, 32'h0000_0001));
        send(mk_start(32'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(mk_word(KIND_STEP));
        send(mk_write(13'd7, 32'h0FFF_FFF8));
        send(mk_start(32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(mk_word(KIND_STEP));

        for (int phase = 1; phase <= 6; phase++) begin
            quiesce();
            case (phase)
                1: load_regs(DSS_W'({$urandom, $urandom}), 8'd1, 13'd1, 14'd64);
                2: load_regs('0, 8'd0, BPS_W'($urandom_range(1, 4096)), 14'd40);
                3: load_regs(DSS_W'({$urandom, $urandom}), 8'd128, 13'd4096, 14'd8192);
                4: load_regs(DSS_W'({$urandom, $urandom}), SPC_W'($urandom_range(1, 16)),
                             BPS_W'($urandom_range(1, 4096)), 14'd0);
                5: load_regs(48'hFFFF_FFFF_FFFF, 8'd255, 13'd0, 14'd8192);
                default: load_regs(DSS_W'({$urandom, $urandom}),
                                   SPC_W'($urandom_range(1, 128)), 13'd8191,
                                   TEV_W'($urandom_range(1, 64)));
            endcase
            tx_idle = (phase != 3 && phase != 5);
            rx_idle = (phase != 3 && phase != 2);
            counted = 0;
            while (counted < PHASE_WORDS) begin
                w = pick_word();
                if (!(w.kind == KIND_UNUSED || (w.kind == KIND_STEP && !sb.walking)))
                    counted++;
                send(w);
            end
        end

        quiesce();
        repeat (4) @(posedge i_clk);
        sb.finish();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : desc_sink
        int unsigned gap;
        desc_t       got;
        desc_ch.ready = 0;
        hold_done     = 0;
        n_descs       = 0;
        @(posedge i_rst_n);
        forever begin
            gap = rx_idle ? $urandom_range(0, 13) : 0;
            // one long stall so the walker backs up into its input
            if (!hold_done && n_descs >= 60) begin
                gap       = HOLD_CYCLES;
                hold_done = 1;
            end
            @(negedge i_clk);
            if (gap != 0) begin
                desc_ch.ready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            desc_ch.ready <= 1;
            do @(posedge i_clk); while (!(desc_ch.valid && desc_ch.ready));
            got.cluster = desc_ch.cluster_number;
            got.sector  = desc_ch.start_sector;
            got.count   = desc_ch.byte_count;
            got.last    = desc_ch.last;
            n_descs++;
            sb.check(got);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((word_ch.valid && word_ch.ready) || (desc_ch.valid && desc_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/fccw_pkg.sv
rtl/fccw_word_if.sv
rtl/fccw_desc_if.sv
rtl/fccw_ram.sv
rtl/fat_cluster_chain_walker.sv
rtl/fccw_checker.sv
test/fat_cluster_chain_walker_test.sv
